// File: rtl/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg: shared types and constants of the snowball path payoff unit
// Register map, outcome codes, configuration bundle and queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sbp_pkg;

  localparam int unsigned MAX_DAYS_DEFAULT = 4095;
  localparam int unsigned REG_COUNT        = 8;
  localparam int unsigned ADDR_W           = $clog2(REG_COUNT) + 2;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [31:0] KO_LEVEL_RST  = 32'hFFFF_FFFF;
  localparam logic [31:0] KI_LEVEL_RST  = 32'h0000_0000;
  localparam logic [11:0] FIRST_OBS_RST = 12'd0;
  localparam logic [11:0] INTERVAL_RST  = 12'd21;
  localparam logic [31:0] DISCOUNT_RST  = 32'hFFFF_FFFF;
  localparam logic [31:0] COUPON_RST    = 32'h0000_0000;
  localparam logic [31:0] INV_INIT_RST  = 32'h0001_0000;
  localparam logic [31:0] ALL_ONES32    = 32'hFFFF_FFFF;
  localparam logic [31:0] Q30_MAX       = 32'h7FFF_FFFF;
  localparam logic [11:0] DAY_LIMIT     = 12'hFFF;

  typedef enum logic [2:0] {
    REG_KO_LEVEL  = 3'd0,
    REG_KI_LEVEL  = 3'd1,
    REG_FIRST_OBS = 3'd2,
    REG_INTERVAL  = 3'd3,
    REG_DISCOUNT  = 3'd4,
    REG_COUPON    = 3'd5,
    REG_INV_INIT  = 3'd6,
    REG_FORCE_KI  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    OUT_NONE = 2'd0,
    OUT_KO   = 2'd1,
    OUT_KI   = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [31:0] ko_level;
    logic [31:0] ki_level;
    logic [11:0] first_obs;
    logic [11:0] interval;
    logic [31:0] discount;
    logic [31:0] coupon;
    logic [31:0] inv_init;
    logic        force_ki;
  } cfg_t;

  // Pulse that reloads the next observation day when first_obs_day is written
  typedef struct packed {
    logic        en;
    logic [11:0] day;
  } obs_load_t;

  typedef struct packed {
    outcome_e    kind;
    logic [11:0] exit_day;
    logic [31:0] disc;
    logic [31:0] price;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/sbp_if.sv
// ----------------------------------------------------------------------------
// sbp_if: valid/ready channels of the snowball path payoff unit
// Daily price input channel and path result output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] price;
  logic        last;

  modport source (output valid, price, last, input ready);
  modport sink   (input valid, price, last, output ready);
endinterface

interface sbp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] payoff;
  logic        [1:0]  outcome;
  logic        [11:0] exit_day;

  modport source (output valid, payoff, outcome, exit_day, input ready);
  modport sink   (input valid, payoff, outcome, exit_day, output ready);
endinterface

`default_nettype wire

// File: rtl/sbp_front.sv
// ----------------------------------------------------------------------------
// sbp_front: per-day path tracking
// Count days, observe knock-out, track minimum and discount, classify path end.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_front #(
  parameter int unsigned MAX_DAYS = sbp_pkg::MAX_DAYS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbp_pkg::cfg_t     cfg_i,
  input  sbp_pkg::obs_load_t load_i,
  sbp_in_if.sink            in_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output sbp_pkg::job_t     q_job_o
);

  localparam logic [11:0] DayCap = 12'((MAX_DAYS < 4095) ? MAX_DAYS : 4095);

  logic [11:0] day_q, day_d;
  logic [11:0] next_obs_q, next_obs_d;
  logic        ko_q, ko_d;
  logic [11:0] ko_day_q, ko_day_d;
  logic [31:0] ko_disc_q, ko_disc_d;
  logic [31:0] min_q, min_d;
  logic [31:0] disc_q, disc_d;

  logic        accept, sched, ko_hit, ko_now;
  logic [11:0] ko_day_now;
  logic [31:0] ko_disc_now, min_now;
  logic [12:0] obs_sum;
  logic [63:0] disc_prod;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign sched       = (day_q == next_obs_q);
  assign min_now     = (in_i.price < min_q) ? in_i.price : min_q;
  assign ko_hit      = (sched || in_i.last) && !ko_q && (in_i.price >= cfg_i.ko_level);
  assign ko_now      = ko_q || ko_hit;
  assign ko_day_now  = ko_hit ? day_q : ko_day_q;
  assign ko_disc_now = ko_hit ? disc_q : ko_disc_q;
  assign obs_sum     = {1'b0, next_obs_q} + {1'b0, cfg_i.interval};
  assign disc_prod   = 64'(disc_q) * 64'(cfg_i.discount);

  always_comb begin
    day_d      = day_q;
    next_obs_d = next_obs_q;
    ko_d       = ko_q;
    ko_day_d   = ko_day_q;
    ko_disc_d  = ko_disc_q;
    min_d      = min_q;
    disc_d     = disc_q;
    q_push_o   = 1'b0;

    q_job_o.price = in_i.price;
    if (ko_now) begin
      q_job_o.kind     = sbp_pkg::OUT_KO;
      q_job_o.exit_day = ko_day_now;
      q_job_o.disc     = ko_disc_now;
    end else if ((min_now <= cfg_i.ki_level) || cfg_i.force_ki) begin
      q_job_o.kind     = sbp_pkg::OUT_KI;
      q_job_o.exit_day = day_q;
      q_job_o.disc     = disc_q;
    end else begin
      q_job_o.kind     = sbp_pkg::OUT_NONE;
      q_job_o.exit_day = day_q;
      q_job_o.disc     = disc_q;
    end

    if (load_i.en) begin
      next_obs_d = load_i.day;
    end

    if (accept) begin
      if (in_i.last) begin
        // Hand the finished path to the back end and start a fresh one
        q_push_o   = 1'b1;
        day_d      = '0;
        next_obs_d = cfg_i.first_obs;
        ko_d       = 1'b0;
        ko_day_d   = '0;
        ko_disc_d  = '0;
        min_d      = sbp_pkg::ALL_ONES32;
        disc_d     = sbp_pkg::ALL_ONES32;
      end else begin
        min_d     = min_now;
        ko_d      = ko_now;
        ko_day_d  = ko_day_now;
        ko_disc_d = ko_disc_now;
        if (sched) begin
          next_obs_d = obs_sum[12] ? sbp_pkg::DAY_LIMIT : obs_sum[11:0];
        end
        if (day_q < DayCap) begin
          day_d = day_q + 12'd1;
        end
        disc_d = disc_prod[63:32];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q      <= '0;
      next_obs_q <= sbp_pkg::FIRST_OBS_RST;
      ko_q       <= 1'b0;
      ko_day_q   <= '0;
      ko_disc_q  <= '0;
      min_q      <= sbp_pkg::ALL_ONES32;
      disc_q     <= sbp_pkg::ALL_ONES32;
    end else begin
      day_q      <= day_d;
      next_obs_q <= next_obs_d;
      ko_q       <= ko_d;
      ko_day_q   <= ko_day_d;
      ko_disc_q  <= ko_disc_d;
      min_q      <= min_d;
      disc_q     <= disc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbp_queue.sv
// ----------------------------------------------------------------------------
// sbp_queue: short job queue between front and back
// Register FIFO of finished paths waiting for payoff evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sbp_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output sbp_pkg::job_t pop_job_o,
  output logic          empty_o
);

  localparam int unsigned Depth = sbp_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  sbp_pkg::job_t   slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_job_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbp_back.sv
// ----------------------------------------------------------------------------
// sbp_back: payoff evaluation sequencer
// Two multiply steps and a finish step per path, then a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sbp_pkg::cfg_t cfg_i,
  input  logic          q_empty_i,
  input  sbp_pkg::job_t q_job_i,
  output logic          q_pop_o,
  sbp_out_if.source     out_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e         st_q, st_d;
  sbp_pkg::job_t  job_q;
  logic [63:0]    a_q, a_d;
  logic [63:0]    p_q, p_d;
  logic           zero_q, zero_d;
  logic           ovld_q, ovld_d;
  logic [31:0]    payoff_q, payoff_d;
  logic [1:0]     outcome_q;
  logic [11:0]    exit_q;

  logic           is_ki, fin_load;
  logic [31:0]    op_a, op_b, mag, op_m;
  logic [43:0]    hi_prod;
  logic [44:0]    cpn_sum;
  logic [31:0]    cpn_pay, ki_pay;

  assign is_ki = (job_q.kind == sbp_pkg::OUT_KI);

  // Step one: coupon times day, or price times reciprocal of initial price
  assign op_a = is_ki ? job_q.price : cfg_i.coupon;
  assign op_b = is_ki ? cfg_i.inv_init : {20'b0, job_q.exit_day};

  // Step two: low coupon word times discount, or shortfall times discount
  assign mag  = 32'd0 - a_q[31:0];
  assign op_m = is_ki ? mag : a_q[31:0];

  // Finish: add high coupon word product, shift and saturate, or shift and negate the loss
  assign hi_prod = 44'(a_q[43:32]) * 44'(job_q.disc);
  assign cpn_sum = {1'b0, hi_prod} + {13'b0, p_q[63:32]};
  assign cpn_pay = (|cpn_sum[44:33]) ? sbp_pkg::Q30_MAX : {1'b0, cpn_sum[32:2]};
  assign ki_pay  = zero_q ? 32'd0 : 32'd0 - {2'b0, p_q[63:34]};

  assign fin_load = (st_q == ST_FIN) && (!ovld_q || out_o.ready);
  assign q_pop_o  = (st_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    st_d     = st_q;
    a_d      = a_q;
    p_d      = p_q;
    zero_d   = zero_q;
    payoff_d = payoff_q;
    ovld_d   = ovld_q;
    if (ovld_q && out_o.ready) begin
      ovld_d = 1'b0;
    end
    unique case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          st_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        a_d  = 64'(op_a) * 64'(op_b);
        st_d = ST_MUL2;
      end
      ST_MUL2: begin
        zero_d = |a_q[63:32];
        if (is_ki && (a_q[31:0] == 32'd0)) begin
          p_d = {job_q.disc, 32'd0};
        end else begin
          p_d = 64'(op_m) * 64'(job_q.disc);
        end
        st_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_load) begin
          payoff_d = is_ki ? ki_pay : cpn_pay;
          ovld_d   = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
    end
    a_q      <= a_d;
    p_q      <= p_d;
    zero_q   <= zero_d;
    payoff_q <= payoff_d;
    if (fin_load) begin
      outcome_q <= job_q.kind;
      exit_q    <= job_q.exit_day;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ovld_q <= ovld_d;
    end
  end

  assign out_o.valid    = ovld_q;
  assign out_o.payoff   = payoff_q;
  assign out_o.outcome  = outcome_q;
  assign out_o.exit_day = exit_q;

endmodule

`default_nettype wire

// File: rtl/snowball_path_payoff_unit.sv
// ----------------------------------------------------------------------------
// snowball_path_payoff_unit: payoff of one simulated snowball note path
// Config registers, per-day front end, job queue and payoff back end.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one daily price per transaction, day 0 first, with last set
//   on the final day. A day is taken every cycle while the job queue has room.
//   out_o carries one transaction per path: payoff (signed Q2.30), outcome
//   and exit day. After the final day is taken, the path passes the queue,
//   the back end's idle pop, two multiply steps and a finish step into the result register.
//   The back end works on one path at a time and pops the next only once
//   idle, so short paths can arrive faster than results drain; once the
//   2-entry queue fills, in_i.ready drops until an entry frees.
//   If the receiver stalls, the result register holds, the back end waits in
//   its finish step, and the front keeps taking days until the queue is full.
//   APB registers sit at 4*index; pready is always high, reads return values.
//   Write configuration only while no path is in flight.
//   Reset loads register defaults, empties the queue and starts a new path.
// ----------------------------------------------------------------------------
`default_nettype none

module snowball_path_payoff_unit #(
  parameter int unsigned MAX_DAYS = sbp_pkg::MAX_DAYS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sbp_in_if.sink                     in_i,
  sbp_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sbp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  sbp_pkg::cfg_t      cfg_q;
  sbp_pkg::obs_load_t obs_load;
  sbp_pkg::job_t      push_job, pop_job;
  sbp_pkg::reg_idx_e  reg_idx;
  logic               wr_en, q_push, q_pop, q_full, q_empty;

  // --------------------------------------------------------------------------
  // Configuration port: write on the access phase, decode word address
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = sbp_pkg::reg_idx_e'(paddr[sbp_pkg::ADDR_W-1:2]);

  // Reload the observation schedule together with first_obs_day
  assign obs_load.en  = wr_en && (reg_idx == sbp_pkg::REG_FIRST_OBS);
  assign obs_load.day = pwdata[11:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ko_level  <= sbp_pkg::KO_LEVEL_RST;
      cfg_q.ki_level  <= sbp_pkg::KI_LEVEL_RST;
      cfg_q.first_obs <= sbp_pkg::FIRST_OBS_RST;
      cfg_q.interval  <= sbp_pkg::INTERVAL_RST;
      cfg_q.discount  <= sbp_pkg::DISCOUNT_RST;
      cfg_q.coupon    <= sbp_pkg::COUPON_RST;
      cfg_q.inv_init  <= sbp_pkg::INV_INIT_RST;
      cfg_q.force_ki  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        sbp_pkg::REG_KO_LEVEL:  cfg_q.ko_level  <= pwdata;
        sbp_pkg::REG_KI_LEVEL:  cfg_q.ki_level  <= pwdata;
        sbp_pkg::REG_FIRST_OBS: cfg_q.first_obs <= pwdata[11:0];
        sbp_pkg::REG_INTERVAL:  cfg_q.interval  <= pwdata[11:0];
        sbp_pkg::REG_DISCOUNT:  cfg_q.discount  <= pwdata;
        sbp_pkg::REG_COUPON:    cfg_q.coupon    <= pwdata;
        sbp_pkg::REG_INV_INIT:  cfg_q.inv_init  <= pwdata;
        sbp_pkg::REG_FORCE_KI:  cfg_q.force_ki  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sbp_pkg::REG_KO_LEVEL:  prdata = cfg_q.ko_level;
      sbp_pkg::REG_KI_LEVEL:  prdata = cfg_q.ki_level;
      sbp_pkg::REG_FIRST_OBS: prdata = {20'b0, cfg_q.first_obs};
      sbp_pkg::REG_INTERVAL:  prdata = {20'b0, cfg_q.interval};
      sbp_pkg::REG_DISCOUNT:  prdata = cfg_q.discount;
      sbp_pkg::REG_COUPON:    prdata = cfg_q.coupon;
      sbp_pkg::REG_INV_INIT:  prdata = cfg_q.inv_init;
      sbp_pkg::REG_FORCE_KI:  prdata = {31'b0, cfg_q.force_ki};
      default:                prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: track the path day by day, classify it on the final day
  // --------------------------------------------------------------------------
  sbp_front #(
    .MAX_DAYS (MAX_DAYS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .load_i   (obs_load),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (push_job)
  );

  // --------------------------------------------------------------------------
  // Job queue: decouple path tracking from payoff evaluation
  // --------------------------------------------------------------------------
  sbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  // --------------------------------------------------------------------------
  // Back end: evaluate payoff and hold it in the result register
  // --------------------------------------------------------------------------
  sbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_job_i   (pop_job),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

`ifndef ASSERT_OFF
  // Never push a finished path into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("path pushed into full job queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // Knock-out and full-term coupons are never negative
  a_coupon_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.outcome != sbp_pkg::OUT_KI)) |-> !out_o.payoff[31])
    else $error("negative coupon payoff");

  // Knock-in loss is never positive
  a_loss_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.outcome == sbp_pkg::OUT_KI)) |->
      (out_o.payoff[31] || (out_o.payoff == 32'sd0)))
    else $error("positive knock-in payoff");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the snowball path payoff unit
// Streams daily prices of simulated paths into the unit, programs its barrier,
// schedule and discount registers over APB between paths, and compares every
// path result against an in-bench predictor of the payoff arithmetic.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 5000;  // cycles without any transaction
  localparam int RANDOM_DAYS   = 1780;  // the directed plan adds a few more days
  localparam int PLAN_LEN      = 27;

  // One path result as it leaves out_o
  typedef struct packed {
    logic [31:0]       payoff;
    sbp_pkg::outcome_e outcome;
    logic [11:0]       exit_day;
  } path_result_t;

  // A result typed into the directed plan, tied to the path that causes it
  typedef struct packed {
    int unsigned  path;
    path_result_t res;
  } fixed_result_t;

  // Directed plan row: either a register write or one day of a path
  typedef struct packed {
    bit                is_reg;
    sbp_pkg::reg_idx_e idx;
    logic [31:0]       value;
    logic [31:0]       price;
    logic              last;
    bit                typed;
    path_result_t      res;
  } plan_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PATTERN,
    RX_BURSTY
  } rx_mode_e;

  // Directed plan. Results are typed in only for the paths right after reset,
  // where the coupon is zero and the discount is one; the rest are predicted.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // zero price at reset: deepest knock-in loss on day 0
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0000_0000, 1'b1, 1'b1,
      '{32'hC000_0001, sbp_pkg::OUT_KI,   12'd0}},
    // top price meets the all-ones barrier: knock-out on day 0
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'hFFFF_FFFF, 1'b1, 1'b1,
      '{32'h0000_0000, sbp_pkg::OUT_KO,   12'd0}},
    // price of one: neither barrier touched, zero coupon
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0001_0000, 1'b1, 1'b1,
      '{32'h0000_0000, sbp_pkg::OUT_NONE, 12'd0}},
    // knocked in, but the final price is back at the initial price
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0000_0000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0001_0000, 1'b1, 1'b1,
      '{32'h0000_0000, sbp_pkg::OUT_KI,   12'd1}},
    // full coupon, half discount per day, barriers at 1.5 and 0.75,
    // first observation on day 2 and no further scheduled observations
    '{1'b1, sbp_pkg::REG_COUPON,    32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b1, sbp_pkg::REG_DISCOUNT,  32'h8000_0000, 32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b1, sbp_pkg::REG_KO_LEVEL,  32'h0001_8000, 32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b1, sbp_pkg::REG_KI_LEVEL,  32'h0000_C000, 32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b1, sbp_pkg::REG_FIRST_OBS, 32'd2,         32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b1, sbp_pkg::REG_INTERVAL,  32'd0,         32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    // high prices off the schedule do not knock out; final day misses too
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0002_0000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0002_0000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0001_0000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0002_0000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0001_0000, 1'b1, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    // dip below knock-in, then a final-day knock-out that takes priority
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0002_0000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0001_0000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0000_4000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0002_0000, 1'b1, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    // first observation beyond any path, knock-in forced
    '{1'b1, sbp_pkg::REG_FIRST_OBS, 32'd4095,      32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b1, sbp_pkg::REG_FORCE_KI,  32'd1,         32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0002_0000, 1'b1, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b1, sbp_pkg::REG_INV_INIT,  32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0000_8000, 1'b0, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}},
    '{1'b0, sbp_pkg::REG_KO_LEVEL,  32'h0,         32'h0000_0001, 1'b1, 1'b0,
      '{32'h0,         sbp_pkg::OUT_NONE, 12'd0}}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [sbp_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  sbp_in_if  in_ch ();
  sbp_out_if out_ch ();

  snowball_path_payoff_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Predictor copy of the register file and of the per-path state
  sbp_pkg::cfg_t cfg_m;
  logic [11:0]   m_day;
  logic [11:0]   m_next_obs;
  logic          m_out;
  logic [11:0]   m_out_day;
  logic [31:0]   m_out_disc;
  logic [31:0]   m_low;
  logic [31:0]   m_disc;

  path_result_t  pending_results [$];
  fixed_result_t fixed_results [$];

  int unsigned paths_sent;      // final days accepted, counted by the sender
  int unsigned paths_taken;     // final days seen by the monitor
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned burst_left;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic void restart_path();
    m_day      = '0;
    m_next_obs = cfg_m.first_obs;
    m_out      = 1'b0;
    m_out_day  = '0;
    m_out_disc = '0;
    m_low      = sbp_pkg::ALL_ONES32;
    m_disc     = sbp_pkg::ALL_ONES32;
  endfunction

  // coupon * day * discount, Q0.32 * int * Q0.32 down to Q2.30, saturated
  function automatic logic [31:0] coupon_value(input logic [11:0] day,
                                               input logic [31:0] disc);
    logic [63:0] accrued;
    logic [63:0] total;
    accrued = 64'(cfg_m.coupon) * 64'(day);
    total   = (accrued >> 32) * 64'(disc) +
              (((accrued & 64'hFFFF_FFFF) * 64'(disc)) >> 32);
    total   = total >> 2;
    return (total > 64'(sbp_pkg::Q30_MAX)) ? sbp_pkg::Q30_MAX : total[31:0];
  endfunction

  // Advance the path by one day; return 1 with the result on the final day
  function automatic bit advance_path_day(input logic [31:0] price, input logic last,
                                          output path_result_t res);
    logic        observed;
    logic [12:0] next_sum;
    logic [63:0] ratio;
    logic [63:0] shortfall;
    logic [63:0] loss;
    res = '0;
    observed = (m_day == m_next_obs);
    if (price < m_low) m_low = price;
    // the final day is always observed; only the first knock-out counts
    if ((observed || last) && !m_out && price >= cfg_m.ko_level) begin
      m_out      = 1'b1;
      m_out_day  = m_day;
      m_out_disc = m_disc;
    end
    if (observed) begin
      next_sum   = {1'b0, m_next_obs} + {1'b0, cfg_m.interval};
      m_next_obs = next_sum[12] ? sbp_pkg::DAY_LIMIT : next_sum[11:0];
    end
    if (!last) begin
      if (m_day < sbp_pkg::DAY_LIMIT) m_day++;
      m_disc = 32'((64'(m_disc) * 64'(cfg_m.discount)) >> 32);
      return 1'b0;
    end
    if (m_out) begin
      res = '{coupon_value(m_out_day, m_out_disc), sbp_pkg::OUT_KO, m_out_day};
    end else if (m_low <= cfg_m.ki_level || cfg_m.force_ki) begin
      // loss is (1 - final/initial) discounted, magnitude truncated
      ratio = 64'(price) * 64'(cfg_m.inv_init);
      loss  = '0;
      if (ratio < 64'h1_0000_0000) begin
        shortfall = 64'h1_0000_0000 - ratio;
        loss = (shortfall == 64'h1_0000_0000) ? 64'(m_disc)
                                              : (shortfall * 64'(m_disc)) >> 32;
        loss = loss >> 2;
      end
      res = '{32'd0 - loss[31:0], sbp_pkg::OUT_KI, m_day};
    end else begin
      res = '{coupon_value(m_day, m_disc), sbp_pkg::OUT_NONE, m_day};
    end
    restart_path();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // APB write: setup phase, access phase, then idle; mirror the value
  task automatic write_reg(input sbp_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sbp_pkg::REG_KO_LEVEL:  cfg_m.ko_level = value;
      sbp_pkg::REG_KI_LEVEL:  cfg_m.ki_level = value;
      sbp_pkg::REG_FIRST_OBS: begin
        cfg_m.first_obs = value[11:0];
        m_next_obs      = value[11:0];
      end
      sbp_pkg::REG_INTERVAL:  cfg_m.interval = value[11:0];
      sbp_pkg::REG_DISCOUNT:  cfg_m.discount = value;
      sbp_pkg::REG_COUPON:    cfg_m.coupon   = value;
      sbp_pkg::REG_INV_INIT:  cfg_m.inv_init = value;
      sbp_pkg::REG_FORCE_KI:  cfg_m.force_ki = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offer one day; the sender runs in bursts with random gaps between them
  task automatic send_day(input logic [31:0] price, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.price <= price;
    in_ch.last  <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
    if (last) paths_sent++;
  endtask

  // Drop valid at the step of the last transaction and start the next burst fresh
  task automatic hold_input();
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait for every path result, then let the back end settle
  task automatic wait_idle();
    while (results_seen != paths_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random walk around the initial price, with an occasional wild price
  task automatic send_path(input int unsigned len);
    longint      level;
    int unsigned d;
    logic [31:0] price;
    level = 64'h1_0000 + $urandom_range(0, 'h2000) - 'h1000;
    for (d = 1; d <= len; d++) begin
      level += longint'($urandom_range(0, 'h3000)) - 'h1800;
      if (level < 0) level = 0;
      price = ($urandom_range(0, 15) == 0) ? $urandom() : 32'(level);
      send_day(price, d == len);
    end
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi,
                                             input logic [31:0] typical);
    int unsigned sel;
    sel = $urandom_range(0, 7);
    return (sel == 0) ? lo : (sel == 1) ? hi : typical;
  endfunction

  // New settings for every register, extremes now and then; barriers mostly near the initial price
  task automatic shuffle_config();
    write_reg(sbp_pkg::REG_KO_LEVEL,  pick_value(32'h0, sbp_pkg::ALL_ONES32,
                                      32'h0001_0000 + $urandom_range(0, 'h3000)));
    write_reg(sbp_pkg::REG_KI_LEVEL,  pick_value(32'h0, sbp_pkg::ALL_ONES32,
                                      32'h0001_0000 - $urandom_range('h1000, 'h5000)));
    write_reg(sbp_pkg::REG_FIRST_OBS, pick_value(32'h0, 32'hFFF, $urandom_range(0, 12)));
    write_reg(sbp_pkg::REG_INTERVAL,  pick_value(32'h0, 32'hFFF, $urandom_range(1, 15)));
    write_reg(sbp_pkg::REG_DISCOUNT,  pick_value(32'h0, sbp_pkg::ALL_ONES32,
                                      sbp_pkg::ALL_ONES32 - $urandom_range(0, 'hFF_FFFF)));
    write_reg(sbp_pkg::REG_COUPON,    pick_value(32'h0, sbp_pkg::ALL_ONES32, $urandom()));
    write_reg(sbp_pkg::REG_INV_INIT,  pick_value(32'h0, sbp_pkg::ALL_ONES32,
                                      ($urandom_range(0, 2) == 0) ? $urandom()
                                                                  : 32'h0001_0000));
    write_reg(sbp_pkg::REG_FORCE_KI,  32'($urandom_range(0, 3) == 0));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned   random_days;
    int unsigned   len;
    fixed_result_t typed_row;
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.price  <= '0;
    in_ch.last   <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    paths_sent   = 0;
    paths_taken  = 0;
    results_seen = 0;
    mismatch_count = 0;
    burst_left   = 0;
    random_days  = 0;
    cfg_m = '{ko_level: sbp_pkg::KO_LEVEL_RST, ki_level: sbp_pkg::KI_LEVEL_RST,
              first_obs: sbp_pkg::FIRST_OBS_RST, interval: sbp_pkg::INTERVAL_RST,
              discount: sbp_pkg::DISCOUNT_RST, coupon: sbp_pkg::COUPON_RST,
              inv_init: sbp_pkg::INV_INIT_RST, force_ki: 1'b0};
    restart_path();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan: register rows only once the unit has gone quiet
    foreach (PLAN[i]) begin
      if (PLAN[i].is_reg) begin
        hold_input();
        wait_idle();
        write_reg(PLAN[i].idx, PLAN[i].value);
      end else begin
        if (PLAN[i].typed) begin
          typed_row = '{paths_sent, PLAN[i].res};
          fixed_results.insert(fixed_results.size(), typed_row);
        end
        send_day(PLAN[i].price, PLAN[i].last);
      end
    end

    // Random phases: new settings, then a handful of whole paths
    while (random_days < RANDOM_DAYS) begin
      hold_input();
      wait_idle();
      shuffle_config();
      repeat ($urandom_range(3, 10)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        send_path(len);
        random_days += len;
      end
    end

    hold_input();
    wait_idle();
    if (pending_results.size() != 0) begin
      $error("%0d path results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready pattern switches between open, fixed-pattern and bursty
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode    = RX_OPEN;
  logic [31:0] rx_pattern = '1;
  int unsigned rx_count   = 0;
  int unsigned rx_stall   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_count == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 2));
        rx_pattern = $urandom() | 32'h1;
        rx_count   = 300;
      end
      rx_count--;
      case (rx_mode)
        RX_OPEN:    out_ch.ready <= 1'b1;
        RX_PATTERN: out_ch.ready <= rx_pattern[rx_count % 32];
        default: begin
          if (rx_stall != 0) begin
            out_ch.ready <= 1'b0;
            rx_stall--;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted day, check every accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    path_result_t  res;
    path_result_t  want;
    fixed_result_t typed_res;
    bit            busy;
    if (rst_ni) begin
      busy = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
             (psel && penable && pwrite && pready);
      quiet_cycles <= busy ? 0 : quiet_cycles + 1;

      if (in_ch.valid && in_ch.ready) begin
        if (advance_path_day(in_ch.price, in_ch.last, res)) begin
          // a typed-in result for this path replaces the prediction
          if (fixed_results.size() != 0 && fixed_results[0].path == paths_taken) begin
            typed_res = fixed_results.pop_front();
            res       = typed_res.res;
          end
          pending_results.insert(pending_results.size(), res);
          paths_taken++;
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("path result with nothing pending: payoff %h outcome %0d exit_day %0d",
                 out_ch.payoff, out_ch.outcome, out_ch.exit_day);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.payoff !== want.payoff) begin
            $error("payoff: expected %h, actual %h", want.payoff, out_ch.payoff);
            mismatch_count++;
          end
          if (out_ch.outcome !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, out_ch.outcome);
            mismatch_count++;
          end
          if (out_ch.exit_day !== want.exit_day) begin
            $error("exit_day: expected %0d, actual %0d", want.exit_day, out_ch.exit_day);
            mismatch_count++;
          end
        end
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Watchdog: end the run if no transaction of any kind moves for too long
  always @(posedge clk_i) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/sbp_pkg.sv
rtl/sbp_if.sv
rtl/sbp_front.sv
rtl/sbp_queue.sv
rtl/sbp_back.sv
rtl/snowball_path_payoff_unit.sv
test/tb.sv
